FILE: design/beaver_dot_product_share_defines.svh
// Assertion macros shared by the checker of beaver_dot_product_share.
// No dependencies; take in with `include.
`ifndef BEAVER_DOT_PRODUCT_SHARE_DEFINES_SVH
`define BEAVER_DOT_PRODUCT_SHARE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BDP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BDP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bdp_pkg.sv
// Shared types, field constants and mod-p helpers for the Beaver dot product share.
// No dependencies.
package bdp_pkg;

    localparam int WORD_W   = 64;
    localparam int NUM_WORD = 7;
    localparam int TDATA_W  = WORD_W * NUM_WORD;
    localparam int MUL_LAT  = 4;

    // p = 2^64 - 59, and 2^64 == 59 (mod p)
    localparam logic [WORD_W-1:0] FIELD_P = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam logic [5:0]        FOLD_K  = 6'd59;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic valid;
        logic last;
    } bdp_ctl_t;

    function automatic word_t red1(input word_t v);
        return (v >= FIELD_P) ? (v - FIELD_P) : v;
    endfunction

    function automatic word_t fadd(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        s = {1'b0, red1(a)} + {1'b0, red1(b)};
        if (s >= {1'b0, FIELD_P}) begin
            s = s - {1'b0, FIELD_P};
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic word_t fsub(input word_t a, input word_t b);
        word_t ra;
        word_t rb;
        ra = red1(a);
        rb = red1(b);
        return (ra >= rb) ? (ra - rb) : (ra - rb + FIELD_P);
    endfunction

endpackage

FILE: design/bdp_open.sv
// Input register and opening of d and e: d = (a-x) + peer_d, e = (b-y) + peer_e.
// Depends on bdp_pkg.
module bdp_open
    import bdp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               s_tvalid,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    output word_t              d_open,
    output word_t              e_open,
    output word_t              x_red,
    output word_t              y_red,
    output word_t              z_red,
    output bdp_ctl_t           ctl_out
);

    logic [TDATA_W-1:0] in_data_reg;
    bdp_ctl_t           in_ctl_reg;

    word_t    own_d_reg, own_e_reg, xa_reg, ya_reg, za_reg, pd_reg, pe_reg;
    bdp_ctl_t a_ctl_reg;

    word_t    d_reg, e_reg, xb_reg, yb_reg, zb_reg;
    bdp_ctl_t b_ctl_reg;

    word_t f_a, f_x, f_b, f_y, f_z, f_pd, f_pe;

    assign f_a  = in_data_reg[0*WORD_W +: WORD_W];
    assign f_x  = in_data_reg[1*WORD_W +: WORD_W];
    assign f_b  = in_data_reg[2*WORD_W +: WORD_W];
    assign f_y  = in_data_reg[3*WORD_W +: WORD_W];
    assign f_z  = in_data_reg[4*WORD_W +: WORD_W];
    assign f_pd = in_data_reg[5*WORD_W +: WORD_W];
    assign f_pe = in_data_reg[6*WORD_W +: WORD_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
            a_ctl_reg  <= '0;
            b_ctl_reg  <= '0;
        end else if (en) begin
            in_ctl_reg <= '{valid: s_tvalid, last: s_tlast};
            a_ctl_reg  <= in_ctl_reg;
            b_ctl_reg  <= a_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_data_reg <= s_tdata;
            own_d_reg   <= fsub(f_a, f_x);
            own_e_reg   <= fsub(f_b, f_y);
            xa_reg      <= red1(f_x);
            ya_reg      <= red1(f_y);
            za_reg      <= red1(f_z);
            pd_reg      <= f_pd;
            pe_reg      <= f_pe;
            d_reg       <= fadd(own_d_reg, pd_reg);
            e_reg       <= fadd(own_e_reg, pe_reg);
            xb_reg      <= xa_reg;
            yb_reg      <= ya_reg;
            zb_reg      <= za_reg;
        end
    end

    assign d_open  = d_reg;
    assign e_open  = e_reg;
    assign x_red   = xb_reg;
    assign y_red   = yb_reg;
    assign z_red   = zb_reg;
    assign ctl_out = b_ctl_reg;

endmodule

FILE: design/bdp_modmul.sv
// Pipelined 64x64 modular multiplier for p = 2^64 - 59, four stages:
// 32-bit partial products, 128-bit product, two folds with 2^64 == 59. Depends on bdp_pkg.
module bdp_modmul
    import bdp_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  word_t op_a,
    input  word_t op_b,
    output word_t prod
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0] full_reg;
    logic [69:0]  fold_reg;
    word_t        res_reg;

    logic [127:0] full_next;
    logic [69:0]  fold_next;
    logic [64:0]  u;
    word_t        res_next;

    always_comb begin
        full_next = {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                  + {hh_reg, 64'd0};
        // operands are reduced, so the high word times 59 stays below 2^70
        fold_next = {6'd0, full_reg[63:0]} + ({6'd0, full_reg[127:64]} * 70'(FOLD_K));
        u         = {1'b0, fold_reg[63:0]} + (65'(fold_reg[69:64]) * 65'(FOLD_K));
        res_next  = (u >= {1'b0, FIELD_P}) ? 64'(u - {1'b0, FIELD_P}) : u[63:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= {32'd0, op_a[31:0]}  * {32'd0, op_b[31:0]};
            lh_reg   <= {32'd0, op_a[31:0]}  * {32'd0, op_b[63:32]};
            hl_reg   <= {32'd0, op_a[63:32]} * {32'd0, op_b[31:0]};
            hh_reg   <= {32'd0, op_a[63:32]} * {32'd0, op_b[63:32]};
            full_reg <= full_next;
            fold_reg <= fold_next;
            res_reg  <= res_next;
        end
    end

    assign prod = res_reg;

endmodule

FILE: design/bdp_accum.sv
// Product share sum, running accumulator and output register with skid stage.
// Depends on bdp_pkg.
module bdp_accum
    import bdp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  word_t    z_red,
    input  word_t    ex_prod,
    input  word_t    dy_prod,
    input  bdp_ctl_t ctl_in,
    output logic     advance,
    output logic     m_tvalid,
    input  logic     m_tready,
    output word_t    m_tdata
);

    word_t    c_reg;
    bdp_ctl_t c_ctl_reg;
    word_t    running_sum_reg;
    logic     out_valid_reg, skid_valid_reg;
    word_t    out_data_reg, skid_data_reg;

    logic [65:0] s3;
    word_t       c_next;
    word_t       sum_next;
    logic        push;

    assign advance = !skid_valid_reg;

    // z + e*x + d*y is below 3p: pick among zero, one or two subtractions
    always_comb begin
        s3 = 66'(z_red) + 66'(ex_prod) + 66'(dy_prod);
        priority if (s3 >= {1'b0, FIELD_P, 1'b0}) begin
            c_next = 64'(s3 - {1'b0, FIELD_P, 1'b0});
        end else if (s3 >= {2'b00, FIELD_P}) begin
            c_next = 64'(s3 - {2'b00, FIELD_P});
        end else begin
            c_next = s3[63:0];
        end
    end

    assign sum_next = fadd(running_sum_reg, c_reg);
    assign push     = advance && c_ctl_reg.valid && c_ctl_reg.last;

    always_ff @(posedge aclk) begin
        if (advance) begin
            c_reg <= c_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_ctl_reg       <= '0;
            running_sum_reg <= '0;
        end else if (advance) begin
            c_ctl_reg <= ctl_in;
            if (c_ctl_reg.valid) begin
                running_sum_reg <= c_ctl_reg.last ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push) begin
                out_data_reg <= sum_next;
            end
        end else if (push) begin
            skid_data_reg <= sum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/beaver_dot_product_share.sv
// Beaver-triple dot product share over p = 2^64 - 59, one party's online step.
// Depends on bdp_pkg, bdp_open, bdp_modmul and bdp_accum.
//
// Usage:
//   Slave channel: one vector element per beat. s_tdata carries this party's
//   shares of a, x, b, y, z and the peer's shares of d and e; s_tlast marks
//   the final element of a vector.
//   Master channel: one beat per vector, carrying this party's share of the
//   dot product (without the d*e term), always a reduced residue.
//   Throughput: one element per cycle while s_tready is high. Every stage up to
//   the share sum runs off one enable; the only loop is the single modular add
//   into the running sum. The s_tlast beat passes the input register, two opening
//   stages, four multiplier stages, the share sum and the output register before
//   m_tvalid rises.
//   Reset clears the running sum and all valid flags; nothing is in flight.
//   Stall: when m_tready is low with a result waiting, the next result goes to
//   a skid register and s_tready drops while that register is full, freezing the
//   pipeline until the master side drains.
module beaver_dot_product_share
    import bdp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // own_a, own_x, own_b, own_y, own_z, peer_d, peer_e (64 bits each, low first)
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // dot_share
    output logic [WORD_W-1:0]  m_tdata
);

    logic     en;
    word_t    d_open, e_open, x_red, y_red, z_red;
    bdp_ctl_t open_ctl;
    word_t    ex_prod, dy_prod;

    bdp_ctl_t ctl_pipe_reg [MUL_LAT];
    word_t    z_pipe_reg   [MUL_LAT];

    assign s_tready = en;

    bdp_open u_open (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .d_open   (d_open),
        .e_open   (e_open),
        .x_red    (x_red),
        .y_red    (y_red),
        .z_red    (z_red),
        .ctl_out  (open_ctl)
    );

    bdp_modmul u_mul_ex (
        .aclk (aclk),
        .en   (en),
        .op_a (e_open),
        .op_b (x_red),
        .prod (ex_prod)
    );

    bdp_modmul u_mul_dy (
        .aclk (aclk),
        .en   (en),
        .op_a (d_open),
        .op_b (y_red),
        .prod (dy_prod)
    );

    // z and control ride alongside the multipliers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                ctl_pipe_reg[i] <= '0;
            end
        end else if (en) begin
            ctl_pipe_reg[0] <= open_ctl;
            for (int i = 1; i < MUL_LAT; i++) begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_pipe_reg[0] <= z_red;
            for (int i = 1; i < MUL_LAT; i++) begin
                z_pipe_reg[i] <= z_pipe_reg[i-1];
            end
        end
    end

    bdp_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .z_red    (z_pipe_reg[MUL_LAT-1]),
        .ex_prod  (ex_prod),
        .dy_prod  (dy_prod),
        .ctl_in   (ctl_pipe_reg[MUL_LAT-1]),
        .advance  (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/bdp_checker.sv
// Port-level checks for beaver_dot_product_share, bound to the top level.
// Depends on bdp_pkg and beaver_dot_product_share_defines.svh.
`include "beaver_dot_product_share_defines.svh"

module bdp_checker
    import bdp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [WORD_W-1:0]  m_tdata
);

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tlast ^ (^s_tdata);

    // result is always a reduced residue
    `BDP_ASSERT_NOW(a_out_reduced, aclk, aresetn, m_tvalid, m_tdata < FIELD_P, "dot_share not reduced")

    // a stalled result beat holds
    `BDP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // input side only stops after the output side held back a beat
    `BDP_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, $past(m_tvalid && !m_tready), "s_tready low without output stall")

    // a cycle with the receiver ready always frees the input side
    `BDP_ASSERT_NEXT(a_stall_release, aclk, aresetn, m_tready, s_tready, "s_tready low after m_tready")

endmodule

bind beaver_dot_product_share bdp_checker u_bdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/tb.sv
// Self-checking testbench for beaver_dot_product_share: random and directed vector elements
// checked against an in-bench mod-p predictor of the accumulated dot product share.
// Depends on bdp_pkg and the beaver_dot_product_share RTL.
module tb;
    import bdp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int NUM_RANDOM  = 840;

    typedef struct packed {
        word_t a;
        word_t x;
        word_t b;
        word_t y;
        word_t z;
        word_t pd;
        word_t pe;
        logic  last;
        logic  hold;   // wait for all pending shares before sending
        logic  burst;  // no gap after this element
    } elem_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [WORD_W-1:0]  m_tdata;

    elem_t elem_q[$];
    word_t share_q[$];
    word_t share_acc = '0;
    elem_t on_bus;
    int    tx_wait = 0;
    int    rx_wait = 0;
    bit    rx_calm = 1'b0;
    int    shares_seen = 0;
    int    stall_after = -1;
    int    hold_left = 0;
    int    err_cnt = 0;
    int    cycle_cnt = 0;

    beaver_dot_product_share u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // field arithmetic done with a wide remainder
    function automatic word_t modp(input logic [127:0] v);
        logic [127:0] r;
        r = v % {64'd0, FIELD_P};
        return r[WORD_W-1:0];
    endfunction

    function automatic word_t fp_add(input word_t a, input word_t b);
        return modp({64'd0, a} + {64'd0, b});
    endfunction

    function automatic word_t fp_sub(input word_t a, input word_t b);
        return modp({64'd0, a} + {64'd0, FIELD_P} - {64'd0, modp({64'd0, b})});
    endfunction

    function automatic word_t fp_mul(input word_t a, input word_t b);
        return modp({64'd0, a} * {64'd0, b});
    endfunction

    // open d and e, add z + e*x + d*y into the running share
    function automatic void accumulate_element(input elem_t el);
        word_t d;
        word_t e;
        word_t c;
        d = fp_add(fp_sub(el.a, el.x), el.pd);
        e = fp_add(fp_sub(el.b, el.y), el.pe);
        c = fp_add(fp_add(el.z, fp_mul(e, el.x)), fp_mul(d, el.y));
        share_acc = fp_add(share_acc, c);
        if (el.last) begin
            share_q.push_back(share_acc);
            share_acc = '0;
        end
    endfunction

    function automatic word_t draw_word();
        int sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0: begin
                return word_t'($urandom_range(0, 15));
            end
            1: begin
                return FIELD_P - 1 - word_t'($urandom_range(0, 15));
            end
            2: begin
                // not reduced: [p, 2^64)
                return FIELD_P + word_t'($urandom_range(0, 58));
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    function automatic elem_t mk_elem(input word_t a, input word_t x, input word_t b,
                                      input word_t y, input word_t z, input word_t pd,
                                      input word_t pe, input logic last);
        elem_t el;
        el.a = a;
        el.x = x;
        el.b = b;
        el.y = y;
        el.z = z;
        el.pd = pd;
        el.pe = pe;
        el.last = last;
        el.hold = 1'b0;
        el.burst = 1'b0;
        return el;
    endfunction

    function automatic elem_t rand_elem(input logic last);
        return mk_elem(draw_word(), draw_word(), draw_word(), draw_word(), draw_word(),
                       draw_word(), draw_word(), last);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_element(on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (elem_q.size() != 0 && !(elem_q[0].hold && share_q.size() != 0)) begin
                    on_bus = elem_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.pe, on_bus.pd, on_bus.z, on_bus.y,
                                 on_bus.b, on_bus.x, on_bus.a};
                    s_tlast  <= on_bus.last;
                    tx_wait = on_bus.burst ? 0 : $urandom_range(0, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long hold-off lets the pipeline fill and back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                shares_seen++;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (m_tvalid && m_tready && shares_seen == stall_after) begin
                hold_left <= LONG_HOLD;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (share_q.size() == 0) begin
                    $error("dot_share: no share pending, got %h", m_tdata);
                    err_cnt++;
                end else if (share_q[0] !== m_tdata) begin
                    $error("dot_share: expected %h, actual %h", share_q[0], m_tdata);
                    err_cnt++;
                    void'(share_q.pop_front());
                end else begin
                    void'(share_q.pop_front());
                end
                if ($urandom_range(0, 29) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("beaver_dot_product_share: mismatch");
        $finish;
    end

    initial begin
        elem_t el;
        word_t all1;
        word_t pm1;
        int    n_last;
        int    n_items;
        int    vlen;
        bit    calm;
        all1 = '1;
        pm1  = FIELD_P - 1;

        // directed: field extremes, unreduced operands, zero openings, short vector
        elem_q.push_back(mk_elem('0, '0, '0, '0, '0, '0, '0, 1'b1));
        elem_q.push_back(mk_elem(pm1, pm1, pm1, pm1, pm1, pm1, pm1, 1'b1));
        elem_q.push_back(mk_elem(all1, all1, all1, all1, all1, all1, all1, 1'b1));
        elem_q.push_back(mk_elem(FIELD_P, FIELD_P, FIELD_P, FIELD_P, FIELD_P, FIELD_P,
                                 FIELD_P, 1'b1));
        elem_q.push_back(mk_elem(pm1, '0, pm1, '0, '0, 64'd1, 64'd1, 1'b1));
        elem_q.push_back(mk_elem('0, pm1, '0, pm1, pm1, all1, all1, 1'b1));
        elem_q.push_back(mk_elem(all1, pm1, '0, all1, pm1, '0, FIELD_P, 1'b1));
        elem_q.push_back(rand_elem(1'b0));
        elem_q.push_back(rand_elem(1'b0));
        elem_q.push_back(rand_elem(1'b1));
        elem_q.push_back(mk_elem('0, '0, '0, '0, all1, '0, '0, 1'b0));
        elem_q.push_back(mk_elem('0, '0, '0, '0, '0, all1, FIELD_P + 58, 1'b1));
        elem_q.push_back(mk_elem({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}},
                                 {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, 1'b0));
        elem_q.push_back(mk_elem({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}},
                                 {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, 1'b1));
        n_last = 0;
        foreach (elem_q[i]) begin
            if (elem_q[i].last) begin
                n_last++;
            end
        end
        stall_after = n_last;

        // back-to-back single-element vectors while the receiver holds off
        for (int i = 0; i < 48; i++) begin
            el = rand_elem(1'b1);
            el.burst = 1'b1;
            el.hold = (i == 0);
            elem_q.push_back(el);
        end

        // random vectors, mostly short, a few long
        n_items = 0;
        calm = 1'b0;
        while (n_items < NUM_RANDOM) begin
            vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            for (int k = 0; k < vlen; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    calm = !calm;
                end
                el = rand_elem(k == vlen - 1);
                el.burst = calm;
                el.hold = (k == 0) && ($urandom_range(0, 29) == 0);
                elem_q.push_back(el);
                n_items++;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (elem_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (share_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("beaver_dot_product_share: match");
        end else begin
            $display("beaver_dot_product_share: mismatch");
        end
        $finish;
    end

endmodule
